FILE: rtl/spint_pkg.sv
// ----------------------------------------------------------------------------
// spint_pkg
// shared types and constants of the spectrum integrator with statistics
// ----------------------------------------------------------------------------
package spint_pkg;

  localparam int unsigned MaxChannelsDef = 4096;
  localparam int unsigned MaxGroupDef    = 256;

  // counts up to 65536 need 17 bits, channel indexes 16
  localparam int unsigned CntW = 17;
  localparam int unsigned IdxW = 16;

  localparam logic [2:0] RegFormat = 3'd0;
  localparam logic [2:0] RegTotal  = 3'd1;
  localparam logic [2:0] RegWStart = 3'd2;
  localparam logic [2:0] RegWWidth = 3'd3;
  localparam logic [2:0] RegGroup  = 3'd4;

  localparam logic KindChannel = 1'b0;
  localparam logic KindStats   = 1'b1;

  typedef struct packed {
    logic signed [31:0] sample;
    logic signed [31:0] quant_mean;
    logic        [30:0] quant_rms;
    logic               end_of_data;
  } in_beat_t;

  typedef struct packed {
    logic               kind;
    logic        [11:0] channel_index;
    logic signed [31:0] value;
    logic        [30:0] spread;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic        sample_format;
    logic [12:0] total_channels;
    logic [11:0] window_start;
    logic [12:0] window_width;
    logic [8:0]  spectra_per_group;
  } cfg_t;

  // one classified element handed from front to back
  typedef struct packed {
    logic signed [31:0] x;
    logic [IdxW-1:0]    idx;
    logic               in_win;
    logic               first;
    logic               closing;
    logic               last_elem;
    logic [CntW-1:0]    n;
    logic [CntW-1:0]    kept;
  } cmd_t;

  typedef struct packed {
    logic            start;
    logic [63:0]     dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

FILE: rtl/spint_front.sv
// ----------------------------------------------------------------------------
// spint_front
// classifies raw elements: dequantization, window and group bookkeeping
// ----------------------------------------------------------------------------
module spint_front #(
  parameter int unsigned MAX_CHANNELS = spint_pkg::MaxChannelsDef,
  parameter int unsigned MAX_GROUP    = spint_pkg::MaxGroupDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spint_pkg::cfg_t     cfg_i,
  input  logic                accept_i,
  input  spint_pkg::in_beat_t in_i,
  output spint_pkg::cmd_t     cmd_o
);
  import spint_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_CHANNELS);
  localparam int unsigned GrpW = $clog2(MAX_GROUP + 1);
  localparam int unsigned WW   = CntW + 1;

  logic [PosW-1:0] pos_q, pos_d;
  logic [GrpW-1:0] grp_q, grp_d;

  logic [WW-1:0] tc, ww, spg, ws, end_win, kept, pw, grp1;
  logic          closing, last_elem, in_win;

  logic signed [7:0]  code;
  logic signed [39:0] prod;
  logic signed [43:0] t;
  logic signed [44:0] dq;
  logic signed [31:0] x;

  always_comb begin
    tc = WW'(cfg_i.total_channels);
    if (tc == '0) tc = WW'(1);
    if (tc > WW'(MAX_CHANNELS)) tc = WW'(MAX_CHANNELS);
    ww = WW'(cfg_i.window_width);
    if (ww > WW'(MAX_CHANNELS)) ww = WW'(MAX_CHANNELS);
    spg = WW'(cfg_i.spectra_per_group);
    if (spg == '0) spg = WW'(1);
    if (spg > WW'(MAX_GROUP)) spg = WW'(MAX_GROUP);
    ws = WW'(cfg_i.window_start);
    end_win = ws + ww;
    if (end_win > tc) end_win = tc;
    kept = (end_win > ws) ? end_win - ws : '0;
    pw = WW'(pos_q);
    grp1 = WW'(grp_q) + WW'(1);
    in_win = (pw >= ws) && (pw < end_win);
    closing = in_i.end_of_data || (grp1 >= spg);
    last_elem = (pw + WW'(1)) >= tc;
  end

  // code * 6/256 * rms, rounded, plus offset, saturated; raw sample when sample_format is 0
  always_comb begin
    code = in_i.sample[7:0];
    prod = 40'(code) * $signed({9'd0, in_i.quant_rms});
    t    = 44'(prod) * 44'sd6 + 44'sd128;
    dq   = 45'(t >>> 8) + 45'(in_i.quant_mean);
    if (dq > 45'sh0_7FFF_FFFF) begin
      x = 32'sh7FFF_FFFF;
    end else if (dq < -45'sh0_8000_0000) begin
      x = 32'sh8000_0000;
    end else begin
      x = dq[31:0];
    end
    if (!cfg_i.sample_format) x = in_i.sample;
  end

  always_comb begin
    cmd_o.x         = x;
    cmd_o.idx       = IdxW'(pw - ws);
    cmd_o.in_win    = in_win;
    cmd_o.first     = (grp_q == '0);
    cmd_o.closing   = closing;
    cmd_o.last_elem = last_elem;
    cmd_o.n         = CntW'(grp1);
    cmd_o.kept      = CntW'(kept);
  end

  always_comb begin
    pos_d = pos_q;
    grp_d = grp_q;
    if (accept_i) begin
      if (last_elem) begin
        pos_d = '0;
        grp_d = closing ? '0 : GrpW'(grp1);
      end else begin
        pos_d = PosW'(pw + WW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      grp_q <= '0;
    end else begin
      pos_q <= pos_d;
      grp_q <= grp_d;
    end
  end

endmodule

FILE: rtl/spint_div.sv
// ----------------------------------------------------------------------------
// spint_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module spint_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spint_pkg::div_req_t req_i,
  output spint_pkg::div_rsp_t rsp_o
);
  import spint_pkg::*;

  logic            busy_q, done_q;
  logic [6:0]      cnt_q;
  logic [63:0]     quo_q;
  logic [CntW-1:0] rem_q, dvs_q;
  logic [CntW:0]   trial;

  assign trial = {rem_q, quo_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= CntW'(trial - {1'b0, dvs_q});
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= CntW'(trial);
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/spint_sqrt.sv
// ----------------------------------------------------------------------------
// spint_sqrt
// integer square root of a 64-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module spint_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spint_pkg::sqrt_req_t req_i,
  output spint_pkg::sqrt_rsp_t rsp_o
);
  import spint_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] x_q, r_q, bit_q, rb;

  assign rb = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.radicand;
      r_q   <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (x_q >= rb) begin
        x_q <= x_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = r_q[31:0];

endmodule

FILE: rtl/spint_back.sv
// ----------------------------------------------------------------------------
// spint_back
// accumulates channels, averages closing spectra, forms mean and rms
// ----------------------------------------------------------------------------
module spint_back #(
  parameter int unsigned MAX_CHANNELS = spint_pkg::MaxChannelsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  spint_pkg::cmd_t      cmd_i,
  output logic                 cmd_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output spint_pkg::out_beat_t out_o
);
  import spint_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_CHANNELS);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SRead = 4'd1;
  localparam logic [3:0] SAcc  = 4'd2;
  localparam logic [3:0] SAvgW = 4'd3;
  localparam logic [3:0] SSq   = 4'd4;
  localparam logic [3:0] SPush = 4'd5;
  localparam logic [3:0] SLast = 4'd6;
  localparam logic [3:0] SMDiv = 4'd7;
  localparam logic [3:0] SMSq  = 4'd8;
  localparam logic [3:0] SSDiv = 4'd9;
  localparam logic [3:0] SSqrt = 4'd10;
  localparam logic [3:0] SEmit = 4'd11;

  localparam logic signed [48:0] SumMax = 49'sh0_7FFF_FFFF_FFFF;

  logic signed [47:0] mem [MAX_CHANNELS];

  logic [3:0]         state_q, state_d;
  cmd_t               cmd_q;
  logic signed [47:0] rdata_q;
  logic               neg_q;
  logic [31:0]        mag_q;
  logic [63:0]        sq_q;
  logic signed [47:0] vsum_q;
  logic [63:0]        ssum_q;
  logic signed [31:0] stat_mean_q;
  logic [30:0]        rms_q;

  logic               mem_we;
  logic signed [48:0] wide;
  logic signed [47:0] s;
  logic [47:0]        smag;
  logic [63:0]        q;
  logic [31:0]        qmag;
  logic signed [48:0] vwide;
  logic [64:0]        swide;
  logic [47:0]        vmag;
  logic [63:0]        var_v;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  // result queue, two entries
  out_beat_t  oq_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q;
  logic       opush, ofull;
  out_beat_t  obeat;

  spint_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  spint_sqrt u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (sq_req),
    .rsp_o (sq_rsp)
  );

  assign ofull   = (ocnt_q == 2'd2);
  assign empty_o = (ocnt_q == 2'd0);
  assign out_o   = oq_q[ord_q];

  always_comb begin
    wide = 49'(rdata_q) + 49'(cmd_q.x);
    if (wide > SumMax) begin
      wide = SumMax;
    end else if (wide < -SumMax) begin
      wide = -SumMax;
    end
    s = cmd_q.first ? 48'(cmd_q.x) : wide[47:0];
    smag = s[47] ? 48'(-s) : 48'(s);
    // clamp of a rounded quotient magnitude to the 32-bit signed range
    q = div_rsp.quotient;
    if (neg_q) begin
      qmag = (q > 64'h8000_0000) ? 32'h8000_0000 : q[31:0];
    end else begin
      qmag = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    vwide = 49'(vsum_q) + 49'($signed(neg_q ? -{1'b0, mag_q} : {1'b0, mag_q}));
    if (vwide > SumMax) begin
      vwide = SumMax;
    end else if (vwide < -SumMax) begin
      vwide = -SumMax;
    end
    swide = 65'(ssum_q) + 65'(sq_q);
    vmag = vsum_q[47] ? 48'(-vsum_q) : 48'(vsum_q);
    var_v = (q > sq_q) ? q - sq_q : '0;
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    opush     = 1'b0;
    obeat     = '0;
    div_req   = '0;
    sq_req    = '0;
    case (state_q)
      SIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = cmd_i.in_win ? SRead : SLast;
        end
      end
      SRead: state_d = SAcc;
      SAcc: begin
        mem_we = 1'b1;
        if (cmd_q.closing) begin
          div_req.start    = 1'b1;
          div_req.dividend = 64'(smag) + 64'(cmd_q.n >> 1);
          div_req.divisor  = cmd_q.n;
          state_d          = SAvgW;
        end else begin
          state_d = SLast;
        end
      end
      SAvgW: if (div_rsp.done) state_d = SSq;
      SSq:   state_d = SPush;
      SPush: begin
        if (!ofull) begin
          opush               = 1'b1;
          obeat.kind          = KindChannel;
          obeat.channel_index = cmd_q.idx[11:0];
          obeat.value         = neg_q ? -$signed(mag_q) : $signed(mag_q);
          state_d             = SLast;
        end
      end
      SLast: begin
        if (!cmd_q.last_elem || !cmd_q.closing) begin
          state_d = SIdle;
        end else if (cmd_q.kept == '0) begin
          state_d = SEmit;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = 64'(vmag) + 64'(cmd_q.kept >> 1);
          div_req.divisor  = cmd_q.kept;
          state_d          = SMDiv;
        end
      end
      SMDiv: if (div_rsp.done) state_d = SMSq;
      SMSq: begin
        div_req.start    = 1'b1;
        div_req.dividend = ssum_q;
        div_req.divisor  = cmd_q.kept;
        state_d          = SSDiv;
      end
      SSDiv: begin
        if (div_rsp.done) begin
          sq_req.start    = 1'b1;
          sq_req.radicand = var_v;
          state_d         = SSqrt;
        end
      end
      SSqrt: if (sq_rsp.done) state_d = SEmit;
      SEmit: begin
        if (!ofull) begin
          opush       = 1'b1;
          obeat.kind  = KindStats;
          obeat.value = stat_mean_q;
          obeat.spread = rms_q;
          obeat.last  = 1'b1;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      vsum_q  <= '0;
      ssum_q  <= '0;
      owr_q   <= 1'b0;
      ord_q   <= 1'b0;
      ocnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == SPush && !ofull) begin
        vsum_q <= vwide[47:0];
        ssum_q <= swide[64] ? '1 : swide[63:0];
      end
      // sums restart after the last element of every spectrum
      if ((state_q == SLast && cmd_q.last_elem && !cmd_q.closing) ||
          (state_q == SEmit && !ofull)) begin
        vsum_q <= '0;
        ssum_q <= '0;
      end
      if (opush) owr_q <= ~owr_q;
      if (pop_i && !empty_o) ord_q <= ~ord_q;
      ocnt_q <= ocnt_q + 2'(opush) - 2'(pop_i && !empty_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) oq_q[owr_q] <= obeat;
    if (cmd_pop_o) cmd_q <= cmd_i;
    case (state_q)
      SAvgW, SMDiv: begin
        if (div_rsp.done) mag_q <= qmag;
      end
      SSq:  sq_q <= mag_q * mag_q;
      SMSq: sq_q <= mag_q * mag_q;
      SLast: begin
        stat_mean_q <= '0;
        rms_q       <= '0;
        neg_q       <= vsum_q[47];
      end
      SAcc: neg_q <= s[47];
      SSqrt: begin
        if (sq_rsp.done) begin
          rms_q <= sq_rsp.root[31] ? 31'h7FFF_FFFF : sq_rsp.root[30:0];
        end
      end
      default: ;
    endcase
    if (state_q == SMSq) stat_mean_q <= neg_q ? -$signed(mag_q) : $signed(mag_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[cmd_q.idx[AddrW-1:0]] <= s;
    rdata_q <= mem[cmd_q.idx[AddrW-1:0]];
  end

endmodule

FILE: rtl/spectrum_integrator_with_stats.sv
// ----------------------------------------------------------------------------
// spectrum_integrator_with_stats
// channel window selection, group averaging and per-spectrum statistics
// ----------------------------------------------------------------------------
// usage
//   input side looks like a queue: drive in_beat_i and push; a beat is taken
//   when push is high and full is low
//   results come out of a queue: while empty is low out_beat_o holds the
//   oldest result; pop with empty low takes it
//   registers are written over cfg_valid_i/cfg_ready_o, index and data; ready
//   is always high, write only while the block is idle
// flow
//   a four entry queue sits between the classifying front and the back
//   end; the back end handles one element at a time
//   element inside the window: its channel sum is read, updated and written back
//   element of a closing spectrum inside the window: averaged by the bit-serial
//   divider shared by averages and statistics
//   last element of a closing spectrum with a non-empty window adds two
//   divisions and a square root
// reset clears counters, sums and both queues; channel sums are not cleared,
// the first spectrum of a group overwrites them
// a stalled receiver fills the two-entry result queue, then the back end and
// the input queue hold, and full rises
// ----------------------------------------------------------------------------
module spectrum_integrator_with_stats #(
  parameter int unsigned MAX_CHANNELS = spint_pkg::MaxChannelsDef,
  parameter int unsigned MAX_GROUP    = spint_pkg::MaxGroupDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  spint_pkg::in_beat_t  in_beat_i,
  output logic                 empty,
  input  logic                 pop,
  output spint_pkg::out_beat_t out_beat_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import spint_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd_new;
  logic accept;

  // command queue between front and back
  cmd_t       cq_q [4];
  logic [1:0] cwr_q, crd_q;
  logic [2:0] ccnt_q;
  logic       cmd_pop;

  assign cfg_ready_o = 1'b1;
  assign full        = (ccnt_q == 3'd4);
  assign accept      = push && !full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_format     <= 1'b0;
      cfg_q.total_channels    <= 13'd4096;
      cfg_q.window_start      <= '0;
      cfg_q.window_width      <= 13'd4096;
      cfg_q.spectra_per_group <= 9'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegFormat: cfg_q.sample_format     <= cfg_data_i[0];
        RegTotal:  cfg_q.total_channels    <= cfg_data_i[12:0];
        RegWStart: cfg_q.window_start      <= cfg_data_i[11:0];
        RegWWidth: cfg_q.window_width      <= cfg_data_i[12:0];
        RegGroup:  cfg_q.spectra_per_group <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  spint_front #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_GROUP   (MAX_GROUP)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .accept_i(accept),
    .in_i    (in_beat_i),
    .cmd_o   (cmd_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwr_q  <= '0;
      crd_q  <= '0;
      ccnt_q <= '0;
    end else begin
      if (accept) cwr_q <= cwr_q + 2'd1;
      if (cmd_pop) crd_q <= crd_q + 2'd1;
      ccnt_q <= ccnt_q + 3'(accept) - 3'(cmd_pop);
    end
  end

  // queue storage carries payload only
  always_ff @(posedge clk_i) begin
    if (accept) cq_q[cwr_q] <= cmd_new;
  end

  spint_back #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(ccnt_q != 3'd0),
    .cmd_i      (cq_q[crd_q]),
    .cmd_pop_o  (cmd_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_o      (out_beat_o)
  );

endmodule

FILE: tb/sv/tb_spectrum_integrator_with_stats.sv
// ----------------------------------------------------------------------------
// tb_spectrum_integrator_with_stats
// self-checking bench for the spectrum integrator with statistics
// ----------------------------------------------------------------------------
// a directed table runs first: sample and dequantization extremes, a spectrum
// cut short by a shrunk register, a group closed early by end_of_data, mixed
// end_of_data flags and an empty window. random phases follow, each with its
// own register setting and idle pattern. every accepted input beat runs
// through a bit-exact predictor that queues the result beats it should cause,
// and each popped result beat is compared field by field with the oldest one
// ----------------------------------------------------------------------------
module tb_spectrum_integrator_with_stats;
  import spint_pkg::*;

  localparam int unsigned ChanMax    = 4096;
  localparam int unsigned GroupMax   = 256;
  localparam int unsigned SettleCyc  = 400;
  localparam int unsigned HoldCyc    = 600;
  localparam longint      CycleLimit = 4_000_000;
  localparam longint      SumSat     = 64'sh7FFF_FFFF_FFFF;
  localparam longint      I32Max     = 64'sh7FFF_FFFF;
  localparam longint      I32Min     = -64'sh8000_0000;
  localparam logic [2:0]  RegUnused  = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_beat_t    in_beat_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_beat_t   out_beat_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = RegFormat;
  logic [15:0] cfg_data_i = '0;

  spectrum_integrator_with_stats dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_beat_i  (in_beat_i),
    .empty      (empty),
    .pop        (pop),
    .out_beat_o (out_beat_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // one row of the directed table: a register write or an input beat
  typedef struct {
    bit          is_write;
    logic [2:0]  reg_idx;
    logic [15:0] reg_data;
    in_beat_t    beat;
    bit          has_want;
    out_beat_t   want;
  } plan_row_t;

  // ---------------------------------------------------------------------------
  // predictor state: register copies and integrator state
  // ---------------------------------------------------------------------------
  int unsigned       fmt_q, total_q, wstart_q, wwidth_q, group_q;
  longint            chan_sum [ChanMax];
  int unsigned       position, grp_cnt;
  longint            value_sum;
  longint unsigned   square_sum;

  out_beat_t         step_res [$];        // beats caused by the latest element
  out_beat_t         pending_results [$]; // expected beats, oldest first
  bit                failed = 1'b0;

  // idle control, shared with the receiver
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_stall_pct = 0;
  int unsigned       hold_req = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // divide with round half away from zero
  function automatic longint div_half_away(longint a, longint unsigned n);
    longint unsigned mag, q;
    mag = a < 0 ? longint'(-a) : longint'(a);
    q = (mag + n / 2) / n;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // integrate one raw channel element, leaving its result beats in step_res
  function automatic void integrate_element(in_beat_t b);
    int unsigned     tc, ww, spg, p, end_win, kept, idx;
    bit              closing, last_elem;
    longint          x, t, q, s, avg, mean;
    longint unsigned mag, sq, mm, ms, var_v, rms;
    out_beat_t       r;
    tc = total_q == 0 ? 1 : (total_q > ChanMax ? ChanMax : total_q);
    ww = wwidth_q > ChanMax ? ChanMax : wwidth_q;
    spg = group_q == 0 ? 1 : (group_q > GroupMax ? GroupMax : group_q);
    p = position;
    end_win = wstart_q + ww;
    if (end_win > tc) end_win = tc;
    kept = end_win > wstart_q ? end_win - wstart_q : 0;

    if (fmt_q != 0) begin
      // code * 6/256 * rms, rounded, plus the offset
      t = 6 * longint'($signed(b.sample[7:0])) * longint'({1'b0, b.quant_rms}) + 128;
      q = t >= 0 ? t / 256 : -((-t + 255) / 256);
      x = clamp(q + longint'($signed(b.quant_mean)), I32Min, I32Max);
    end else begin
      x = longint'($signed(b.sample));
    end

    closing = b.end_of_data || (grp_cnt + 1 >= spg);
    last_elem = p + 1 >= tc;
    step_res.delete();

    if (p >= wstart_q && p < end_win) begin
      idx = p - wstart_q;
      s = grp_cnt == 0 ? x : chan_sum[idx] + x;
      s = clamp(s, -SumSat, SumSat);
      chan_sum[idx] = s;
      if (closing) begin
        avg = clamp(div_half_away(s, grp_cnt + 1), I32Min, I32Max);
        mag = avg < 0 ? longint'(-avg) : longint'(avg);
        sq = mag * mag;
        value_sum = clamp(value_sum + avg, -SumSat, SumSat);
        square_sum = square_sum > ~64'd0 - sq ? ~64'd0 : square_sum + sq;
        r = '{kind: KindChannel, channel_index: idx[11:0], value: avg[31:0],
              spread: '0, last: 1'b0};
        step_res.push_back(r);
      end
    end

    if (last_elem) begin
      if (closing) begin
        mean = 0;
        rms = 0;
        if (kept > 0) begin
          mean = clamp(div_half_away(value_sum, kept), I32Min, I32Max);
          mm = mean < 0 ? longint'(-mean) : longint'(mean);
          ms = square_sum / kept;
          var_v = ms > mm * mm ? ms - mm * mm : 0;
          rms = int_sqrt(var_v);
          if (rms > 64'h7FFF_FFFF) rms = 64'h7FFF_FFFF;
        end
        r = '{kind: KindStats, channel_index: '0, value: mean[31:0],
              spread: rms[30:0], last: 1'b1};
        step_res.push_back(r);
        grp_cnt = 0;
      end else begin
        grp_cnt = (grp_cnt + 1) & 9'h1FF;
      end
      value_sum = 0;
      square_sum = 0;
      position = 0;
    end else begin
      position = p + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender: random idle cycles, then hold the beat until full is low
  // ---------------------------------------------------------------------------
  task automatic send_item(in_beat_t b, bit has_want, out_beat_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    in_beat_i <= b;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    integrate_element(b);
    if (has_want) pending_results.push_back(want);
    else foreach (step_res[k]) pending_results.push_back(step_res[k]);
  endtask

  // register write once the block has drained
  task automatic settle_then_write(logic [2:0] idx, logic [15:0] data);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // elements without a result may still be in flight
    repeat (SettleCyc) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegFormat: fmt_q = data & 16'h1;
      RegTotal:  total_q = data & 16'h1FFF;
      RegWStart: wstart_q = data & 16'h0FFF;
      RegWWidth: wwidth_q = data & 16'h1FFF;
      RegGroup:  group_q = data & 16'h01FF;
      default: ;
    endcase
  endtask

  function automatic plan_row_t item_row(logic [31:0] s, logic [31:0] m,
                                         logic [30:0] r, logic e,
                                         bit has_want, out_beat_t w);
    plan_row_t row;
    row.is_write = 1'b0;
    row.reg_idx = RegFormat;
    row.reg_data = '0;
    row.beat = '{sample: s, quant_mean: m, quant_rms: r, end_of_data: e};
    row.has_want = has_want;
    row.want = w;
    return row;
  endfunction

  function automatic plan_row_t write_row(logic [2:0] idx, logic [15:0] data);
    plan_row_t row;
    row = item_row('0, '0, '0, 1'b0, 1'b0, '0);
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stalls, long hold-off on request, compare each beat
  // ---------------------------------------------------------------------------
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  out_beat_t   oldest;

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: got %h", $time, out_beat_o);
        failed = 1'b1;
      end else begin
        oldest = pending_results.pop_front();
        if (out_beat_o.kind !== oldest.kind ||
            out_beat_o.channel_index !== oldest.channel_index ||
            out_beat_o.value !== oldest.value ||
            out_beat_o.spread !== oldest.spread ||
            out_beat_o.last !== oldest.last) begin
          $display("%0t: mismatch expected kind %0d idx %0d value %h spread %h last %0d",
                   $time, oldest.kind, oldest.channel_index, oldest.value,
                   oldest.spread, oldest.last);
          $display("%0t:            actual kind %0d idx %0d value %h spread %h last %0d",
                   $time, out_beat_o.kind, out_beat_o.channel_index, out_beat_o.value,
                   out_beat_o.spread, out_beat_o.last);
          failed = 1'b1;
        end
      end
    end
    // a new hold-off request starts a long stall counted here
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCyc;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= $urandom_range(99) >= rx_stall_pct;
    end
  end

  // watchdog
  longint cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t   plan [$];
    in_beat_t    b;
    int unsigned tc_eff, goal, n, tot, ws, ww, grp;
    bit          final_spec, only_last;

    // predictor reset state
    fmt_q = 0;
    total_q = 4096;
    wstart_q = 0;
    wwidth_q = 4096;
    group_q = 1;
    foreach (chan_sum[k]) chan_sum[k] = 0;
    position = 0;
    grp_cnt = 0;
    value_sum = 0;
    square_sum = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: every element closes its own group, avg is the sample
    plan.push_back(item_row(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0, 1,
                   '{KindChannel, 12'd0, 32'h7FFF_FFFF, 31'd0, 1'b0}));
    plan.push_back(item_row(32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 1'b0, 1,
                   '{KindChannel, 12'd1, 32'h8000_0000, 31'd0, 1'b0}));
    plan.push_back(item_row(32'h0, 32'hFFFF_FFFF, 31'h5555_5555, 1'b0, 1,
                   '{KindChannel, 12'd2, 32'h0, 31'd0, 1'b0}));
    // shrinking total_channels under the position ends the spectrum
    plan.push_back(write_row(RegTotal, 16'd2));
    plan.push_back(item_row(32'd5, 32'h0, 31'd0, 1'b0, 0, '0));
    // 8-bit codes at both extremes, group of three, one-channel window
    plan.push_back(write_row(RegFormat, 16'd1));
    plan.push_back(write_row(RegTotal, 16'd3));
    plan.push_back(write_row(RegWStart, 16'd1));
    plan.push_back(write_row(RegWWidth, 16'd1));
    plan.push_back(write_row(RegGroup, 16'd3));
    plan.push_back(write_row(RegUnused, 16'hFFFF));
    plan.push_back(item_row(32'h0000_007F, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 0, '0));
    plan.push_back(item_row(32'hFFFF_FF80, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0, 0, '0));
    plan.push_back(item_row(32'hAAAA_AA7F, 32'h0, 31'd0, 1'b0, 0, '0));
    // second spectrum closes the partial group, with mixed end flags
    plan.push_back(item_row(32'h0000_0080, 32'h0, 31'h7FFF_FFFF, 1'b0, 0, '0));
    plan.push_back(item_row(32'h5555_557F, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1, 0, '0));
    plan.push_back(item_row(32'h0, 32'h7FFF_FFFF, 31'd0, 1'b1, 0, '0));
    // zero registers: one channel per spectrum, empty window, zero stats
    plan.push_back(write_row(RegTotal, 16'd0));
    plan.push_back(write_row(RegWWidth, 16'd0));
    plan.push_back(item_row(32'h0, 32'h0, 31'd0, 1'b1, 1,
                   '{KindStats, 12'd0, 32'h0, 31'd0, 1'b1}));

    foreach (plan[i]) begin
      if (plan[i].is_write) settle_then_write(plan[i].reg_idx, plan[i].reg_data);
      else send_item(plan[i].beat, plan[i].has_want, plan[i].want);
    end

    // random phases, the last one a single long spectrum whose window runs
    // past its end
    for (int ph = 0; ph < 8; ph++) begin
      tot = $urandom_range(1, 24);
      ws = $urandom_range(0, tot + 2);
      ww = $urandom_range(0, tot + 2);
      grp = $urandom_range(1, 4);
      goal = 200;
      case (ph)
        0: begin
          ws = 0;
          ww = 16'hFFFF;
          grp = 256;
        end
        1: ws = 4095;
        3: grp = 16'hFFFF;
        5: grp = 0;
        6: ww = 4096;
        7: begin
          tot = 600;
          ws = 550;
          ww = 100;
          grp = 1;
          goal = 1;
        end
        default: ;
      endcase
      settle_then_write(RegFormat, 16'($urandom_range(0, 1)));
      settle_then_write(RegTotal, 16'(tot));
      settle_then_write(RegWStart, 16'(ws));
      settle_then_write(RegWWidth, 16'(ww));
      settle_then_write(RegGroup, 16'(grp));
      case (ph % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 69;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 69;
        end
        default: begin
          tx_idle_pct = 11;
          rx_stall_pct = 11;
        end
      endcase
      // receiver holds off while the sender keeps pushing
      if (ph == 0) hold_req = hold_req + 1;

      tc_eff = total_q == 0 ? 1 : (total_q > ChanMax ? ChanMax : total_q);
      n = 0;
      while (n < goal) begin
        final_spec = n + tc_eff >= goal;
        only_last = $urandom_range(0, 3) == 0;
        for (int e = 0; e < tc_eff; e++) begin
          b.sample = $urandom;
          case ($urandom_range(0, 9))
            0: b.sample = 32'h7FFF_FFFF;
            1: b.sample = 32'h8000_0000;
            default: ;
          endcase
          b.quant_mean = $urandom;
          if ($urandom_range(0, 3) == 0) b.quant_mean = $urandom_range(0, 1) ? 32'h7FFF_FFFF
                                                                           : 32'h8000_0000;
          b.quant_rms = $urandom;
          if ($urandom_range(0, 2) == 0) b.quant_rms = $urandom_range(0, 262144);
          // the last spectrum of a phase closes its group
          if (final_spec) b.end_of_data = only_last ? (e == tc_eff - 1) : 1'b1;
          else b.end_of_data = $urandom_range(99) < 2;
          send_item(b, 1'b0, '0);
          n++;
        end
      end
    end

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    if (!failed && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/spint_pkg.sv
rtl/spint_front.sv
rtl/spint_div.sv
rtl/spint_sqrt.sv
rtl/spint_back.sv
rtl/spectrum_integrator_with_stats.sv
tb/sv/tb_spectrum_integrator_with_stats.sv
